/* sv/fenwick_prefix_sum_tree_macros.svh */
// Assertion macros for the RTL of the prefix sum tree.
`ifndef FENWICK_PREFIX_SUM_TREE_MACROS_SVH
`define FENWICK_PREFIX_SUM_TREE_MACROS_SVH
`ifndef SYNTH
`define FPST_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define FPST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FPST_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define FPST_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* sv/fpst_pkg.sv */
package fpst_pkg;

    localparam int POS_W  = 11;
    localparam int DATA_W = 32;

    localparam logic MODE_QUERY  = 1'b0;
    localparam logic MODE_UPDATE = 1'b1;

    typedef logic [DATA_W-1:0] t_word;

endpackage

/* sv/fpst_ram.sv */
module fpst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* sv/fenwick_prefix_sum_tree.sv */
// Fenwick prefix sum tree over SIZE 32-bit node sums held in one simple dual-port RAM.
// After reset the block clears the RAM, one entry a cycle, and holds o_stall high until the
// last entry is cleared. It then takes one item at a time. A query at position p walks down
// through popcount(min(p, SIZE)) nodes. An update walks up from p until it passes SIZE. The
// read of the next node overlaps the write-back of the current one. An item visits at most
// log2(SIZE) + 1 nodes. Queries and updates at position 0, and updates above SIZE, visit no
// node. The result sits in an output register, so the next item can be taken while it waits;
// that item finishes only once the register is free, and every cycle it waits there adds to
// its time. Updates return 0. Sums wrap modulo 2^32.
`include "fenwick_prefix_sum_tree_macros.svh"

module fenwick_prefix_sum_tree #(
    parameter int SIZE = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_mode,
    input  logic [fpst_pkg::POS_W-1:0]          i_position,
    input  logic signed [fpst_pkg::DATA_W-1:0]  i_delta,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [fpst_pkg::DATA_W-1:0]  o_prefix_total
);
    import fpst_pkg::*;

    localparam int AW = $clog2(SIZE);
    localparam int KW = $clog2(SIZE) + 2;
    localparam logic [KW-1:0] SIZE_K = KW'(SIZE);
    localparam logic [AW-1:0] LAST_ADDR = AW'(SIZE - 1);

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_WALK} t_state;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_clr, n_clr;
    logic [KW-1:0]   r_ptr, n_ptr;
    logic [AW-1:0]   r_node, n_node;
    logic            r_pend, n_pend;
    logic            r_mode, n_mode;
    t_word           r_delta, n_delta;
    t_word           r_acc, n_acc;
    logic            r_out_valid, n_out_valid;
    t_word           r_out_total, n_out_total;

    logic            in_xfer;
    logic            active;
    logic            over;
    logic [KW-1:0]   next_ptr;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    t_word           wr_data;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    t_word           rd_data;

    assign o_stall = (r_state != S_IDLE);
    assign in_xfer = i_valid && !o_stall;
    assign over    = (32'(i_position) > 32'(SIZE));
    assign active  = (r_state == S_WALK) && (r_ptr != '0) && (r_ptr <= SIZE_K);
    assign next_ptr = (r_mode == MODE_UPDATE) ? (r_ptr + (r_ptr & (~r_ptr + KW'(1))))
                                              : (r_ptr & (r_ptr - KW'(1)));

    assign rd_en   = active;
    assign rd_addr = AW'(r_ptr - KW'(1));

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_node;
        wr_data = rd_data + r_delta;
        if (r_state == S_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = r_clr;
            wr_data = '0;
        end else if (r_state == S_WALK && r_pend && r_mode == MODE_UPDATE) begin
            wr_en = 1'b1;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_ptr       = r_ptr;
        n_node      = r_node;
        n_pend      = 1'b0;
        n_mode      = r_mode;
        n_delta     = r_delta;
        n_acc       = r_acc;
        n_out_valid = r_out_valid && i_stall;
        n_out_total = r_out_total;
        unique case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + AW'(1);
                if (r_clr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_WALK;
                    n_mode  = i_mode;
                    n_delta = t_word'(i_delta);
                    n_acc   = '0;
                    if (i_mode == MODE_UPDATE) begin
                        n_ptr = (i_position == '0 || over) ? '0 : KW'(i_position);
                    end else begin
                        n_ptr = over ? SIZE_K : KW'(i_position);
                    end
                end
            end
            S_WALK: begin
                if (active) begin
                    n_ptr  = next_ptr;
                    n_node = rd_addr;
                    n_pend = 1'b1;
                end
                if (r_pend && r_mode == MODE_QUERY) begin
                    n_acc = r_acc + rd_data;
                end
                if (!active && !r_pend && (!r_out_valid || !i_stall)) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_out_total = (r_mode == MODE_UPDATE) ? '0 : r_acc;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_ptr       <= n_ptr;
        r_node      <= n_node;
        r_mode      <= n_mode;
        r_delta     <= n_delta;
        r_acc       <= n_acc;
        r_out_total <= n_out_total;
    end

    fpst_ram #(
        .WIDTH (DATA_W),
        .DEPTH (SIZE)
    ) u_node_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_valid        = r_out_valid;
    assign o_prefix_total = r_out_total;

    `FPST_ASSERT_SAME(a_no_wr_idle, i_clk, i_rst_n, r_state == S_IDLE, !wr_en)
    `FPST_ASSERT_SAME(a_query_no_wr, i_clk, i_rst_n, r_state == S_WALK && r_mode == MODE_QUERY, !wr_en)
    `FPST_ASSERT_SAME(a_rd_wr_apart, i_clk, i_rst_n, rd_en && wr_en, rd_addr != wr_addr)
    `FPST_ASSERT_NEXT(a_xfer_walk, i_clk, i_rst_n, in_xfer, r_state == S_WALK)
    `FPST_ASSERT_NEXT(a_read_pend, i_clk, i_rst_n, rd_en, r_pend && r_state == S_WALK)

endmodule
